/* sv/acbc_pkg.sv */
package acbc_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register indexes, taken from paddr[4:2]
   localparam logic [2:0] REG_TICKS_PER_SECOND       = 3'd0;
   localparam logic [2:0] REG_ALARM_DURATION_MINUTES = 3'd1;
   localparam logic [2:0] REG_STEP_DEBOUNCE_POLLS    = 3'd2;
   localparam logic [2:0] REG_SET_TIME_HOLD_POLLS    = 3'd3;
   localparam logic [2:0] REG_SET_ALARM_HOLD_POLLS   = 3'd4;
   localparam logic [2:0] REG_BUZZER_ON_TICKS        = 3'd5;

   localparam logic [7:0] RST_TICKS_PER_SECOND       = 8'd8;
   localparam logic [7:0] RST_ALARM_DURATION_MINUTES = 8'd1;
   localparam logic [7:0] RST_STEP_DEBOUNCE_POLLS    = 8'd2;
   localparam logic [7:0] RST_SET_TIME_HOLD_POLLS    = 8'd30;
   localparam logic [7:0] RST_SET_ALARM_HOLD_POLLS   = 8'd12;
   localparam logic [7:0] RST_BUZZER_ON_TICKS        = 8'd4;

   localparam logic [5:0] MINUTES_WRAP   = 6'd60;
   localparam logic [4:0] HOURS_WRAP     = 5'd24;
   localparam logic [5:0] RELEASE_SECOND = 6'd3;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic {
      OP_POLL = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      BUZZ_KEEP = 2'd0,
      BUZZ_ON   = 2'd1,
      BUZZ_OFF  = 2'd2
   } buzz_type;

   typedef struct packed {
      logic [7:0] ticks_per_second;
      logic [7:0] alarm_duration_minutes;
      logic [7:0] step_debounce_polls;
      logic [7:0] set_time_hold_polls;
      logic [7:0] set_alarm_hold_polls;
      logic [7:0] buzzer_on_ticks;
   } cfg_type;

   typedef struct packed {
      op_type      opcode;
      logic        minutes_button;
      logic        hours_button;
      logic        set_time_button;
      logic        set_alarm_button;
      logic [4:0]  clock_hours;
      logic [5:0]  clock_minutes;
      logic [5:0]  clock_seconds;
      logic [15:0] startup_ticks;
      logic [15:0] buzzer_ticks;
   } req_item_type;

   typedef struct packed {
      logic [4:0] new_hours;
      logic [5:0] new_minutes;
      logic [5:0] new_seconds;
      logic       mode;
      logic       time_frozen;
      logic       clear_fine_timer;
      logic       clear_buzzer_ticks;
      buzz_type   buzzer_action;
      logic       restart_startup;
   } rsp_item_type;

   function automatic logic [5:0] bump_minutes(input logic [5:0] v);
      logic [5:0] n;
      n = v + 6'd1;
      return (n >= MINUTES_WRAP) ? 6'd0 : n;
   endfunction

   function automatic logic [4:0] bump_hours(input logic [4:0] v);
      logic [4:0] n;
      n = v + 5'd1;
      return (n >= HOURS_WRAP) ? 5'd0 : n;
   endfunction

   // x * 60 as shifts, 14 bits hold 255 * 60
   function automatic logic [13:0] times_sixty(input logic [7:0] x);
      return {x, 6'b0} - {4'b0, x, 2'b0};
   endfunction

endpackage

/* sv/acbc_csr.sv */
module acbc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [acbc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [acbc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [acbc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output acbc_pkg::cfg_type                 cfg
);

   acbc_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [2:0]        reg_idx;
   logic [7:0]        rd_byte;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            acbc_pkg::REG_TICKS_PER_SECOND:       cfg_in.ticks_per_second = pwdata[7:0];
            acbc_pkg::REG_ALARM_DURATION_MINUTES: cfg_in.alarm_duration_minutes = pwdata[7:0];
            acbc_pkg::REG_STEP_DEBOUNCE_POLLS:    cfg_in.step_debounce_polls = pwdata[7:0];
            acbc_pkg::REG_SET_TIME_HOLD_POLLS:    cfg_in.set_time_hold_polls = pwdata[7:0];
            acbc_pkg::REG_SET_ALARM_HOLD_POLLS:   cfg_in.set_alarm_hold_polls = pwdata[7:0];
            acbc_pkg::REG_BUZZER_ON_TICKS:        cfg_in.buzzer_on_ticks = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         acbc_pkg::REG_TICKS_PER_SECOND:       rd_byte = cfg_ff.ticks_per_second;
         acbc_pkg::REG_ALARM_DURATION_MINUTES: rd_byte = cfg_ff.alarm_duration_minutes;
         acbc_pkg::REG_STEP_DEBOUNCE_POLLS:    rd_byte = cfg_ff.step_debounce_polls;
         acbc_pkg::REG_SET_TIME_HOLD_POLLS:    rd_byte = cfg_ff.set_time_hold_polls;
         acbc_pkg::REG_SET_ALARM_HOLD_POLLS:   rd_byte = cfg_ff.set_alarm_hold_polls;
         acbc_pkg::REG_BUZZER_ON_TICKS:        rd_byte = cfg_ff.buzzer_on_ticks;
         default:                              rd_byte = 8'd0;
      endcase
   end

   assign prdata = {{(acbc_pkg::CSR_DATA_W-8){1'b0}}, rd_byte};
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_second       <= acbc_pkg::RST_TICKS_PER_SECOND;
         cfg_ff.alarm_duration_minutes <= acbc_pkg::RST_ALARM_DURATION_MINUTES;
         cfg_ff.step_debounce_polls    <= acbc_pkg::RST_STEP_DEBOUNCE_POLLS;
         cfg_ff.set_time_hold_polls    <= acbc_pkg::RST_SET_TIME_HOLD_POLLS;
         cfg_ff.set_alarm_hold_polls   <= acbc_pkg::RST_SET_ALARM_HOLD_POLLS;
         cfg_ff.buzzer_on_ticks        <= acbc_pkg::RST_BUZZER_ON_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/acbc_core.sv */
module acbc_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  acbc_pkg::req_item_type  item,
   input  acbc_pkg::cfg_type       cfg,
   output acbc_pkg::rsp_item_type  result
);

   logic [7:0]  minute_hold_count_ff, minute_hold_count_in;
   logic [7:0]  hour_hold_count_ff, hour_hold_count_in;
   logic [7:0]  long_hold_count_ff, long_hold_count_in;
   logic        alarm_set_mode_ff, alarm_set_mode_in;
   logic        freeze_flag_ff, freeze_flag_in;
   logic [4:0]  alarm_hours_ff, alarm_hours_in;
   logic [5:0]  alarm_minutes_ff, alarm_minutes_in;
   logic        hour_matched_ff, hour_matched_in;
   logic        minute_matched_ff, minute_matched_in;
   logic [13:0] ring_seconds_ff, ring_seconds_in;

   logic [4:0]  hh;
   logic [5:0]  mm;
   logic [5:0]  ss;
   logic        clr_fine;
   logic        clr_buzz;
   logic        restart;
   acbc_pkg::buzz_type action;
   logic [13:0] lockout;
   logic [13:0] ring_limit;

   assign lockout    = acbc_pkg::times_sixty(cfg.ticks_per_second);
   assign ring_limit = acbc_pkg::times_sixty(cfg.alarm_duration_minutes);

   always_comb begin
      minute_hold_count_in = minute_hold_count_ff;
      hour_hold_count_in   = hour_hold_count_ff;
      long_hold_count_in   = long_hold_count_ff;
      alarm_set_mode_in    = alarm_set_mode_ff;
      freeze_flag_in       = freeze_flag_ff;
      alarm_hours_in       = alarm_hours_ff;
      alarm_minutes_in     = alarm_minutes_ff;
      hour_matched_in      = hour_matched_ff;
      minute_matched_in    = minute_matched_ff;
      ring_seconds_in      = ring_seconds_ff;
      hh       = item.clock_hours;
      mm       = item.clock_minutes;
      ss       = item.clock_seconds;
      clr_fine = 1'b0;
      clr_buzz = 1'b0;
      restart  = 1'b0;
      action   = acbc_pkg::BUZZ_KEEP;

      case (item.opcode)
         acbc_pkg::OP_POLL: begin
            // clock-mode steps see the mode from before this poll
            if (item.minutes_button && !alarm_set_mode_in) begin
               minute_hold_count_in = minute_hold_count_in + 8'd1;
               if (minute_hold_count_in >= cfg.step_debounce_polls) begin
                  minute_hold_count_in = 8'd0;
                  mm = acbc_pkg::bump_minutes(mm);
               end
            end
            if (item.hours_button && !alarm_set_mode_in) begin
               hour_hold_count_in = hour_hold_count_in + 8'd1;
               if (hour_hold_count_in >= cfg.step_debounce_polls) begin
                  hour_hold_count_in = 8'd0;
                  hh = acbc_pkg::bump_hours(hh);
               end
            end
            if (item.set_time_button) begin
               long_hold_count_in = long_hold_count_in + 8'd1;
               if (long_hold_count_in >= cfg.set_time_hold_polls && !freeze_flag_in) begin
                  freeze_flag_in     = 1'b1;
                  hh                 = 5'd0;
                  mm                 = 6'd0;
                  ss                 = 6'd0;
                  long_hold_count_in = 8'd0;
               end
               // a zero threshold releases in the same poll
               if (long_hold_count_in >= cfg.set_time_hold_polls && freeze_flag_in) begin
                  freeze_flag_in     = 1'b0;
                  clr_fine           = 1'b1;
                  ss                 = acbc_pkg::RELEASE_SECOND;
                  long_hold_count_in = 8'd0;
               end
            end
            if (item.set_alarm_button) begin
               long_hold_count_in = long_hold_count_in + 8'd1;
               if (long_hold_count_in >= cfg.set_alarm_hold_polls && !alarm_set_mode_in) begin
                  alarm_set_mode_in  = 1'b1;
                  long_hold_count_in = 8'd0;
               end
               if (long_hold_count_in >= cfg.set_alarm_hold_polls && alarm_set_mode_in) begin
                  alarm_set_mode_in  = 1'b0;
                  clr_fine           = 1'b1;
                  long_hold_count_in = 8'd0;
               end
            end
            // alarm-mode steps see the mode after the set-alarm hold
            if (item.minutes_button && alarm_set_mode_in) begin
               minute_hold_count_in = minute_hold_count_in + 8'd1;
               if (minute_hold_count_in >= cfg.step_debounce_polls) begin
                  minute_hold_count_in = 8'd0;
                  alarm_minutes_in     = acbc_pkg::bump_minutes(alarm_minutes_in);
               end
            end
            if (item.hours_button && alarm_set_mode_in) begin
               hour_hold_count_in = hour_hold_count_in + 8'd1;
               if (hour_hold_count_in >= cfg.step_debounce_polls) begin
                  hour_hold_count_in = 8'd0;
                  alarm_hours_in     = acbc_pkg::bump_hours(alarm_hours_in);
               end
            end
         end
         acbc_pkg::OP_TICK: begin
            if (item.startup_ticks >= {2'b0, lockout} && !alarm_set_mode_ff) begin
               if (item.clock_hours == alarm_hours_ff) hour_matched_in = 1'b1;
               if (item.clock_minutes == alarm_minutes_ff) minute_matched_in = 1'b1;
               if (hour_matched_in && minute_matched_in) begin
                  if (item.buzzer_ticks >= {8'b0, cfg.buzzer_on_ticks}) begin
                     action = acbc_pkg::BUZZ_OFF;
                  end
                  if (item.buzzer_ticks >= {8'b0, cfg.ticks_per_second}) begin
                     clr_buzz        = 1'b1;
                     action          = acbc_pkg::BUZZ_ON;
                     ring_seconds_in = ring_seconds_in + 14'd1;
                  end
               end
               // ring time over: drop the alarm and restart the lockout
               if (ring_seconds_in >= ring_limit) begin
                  action            = acbc_pkg::BUZZ_OFF;
                  hour_matched_in   = 1'b0;
                  minute_matched_in = 1'b0;
                  ring_seconds_in   = 14'd0;
                  restart           = 1'b1;
               end
            end
         end
         default: ;
      endcase

      result.new_hours          = hh;
      result.new_minutes        = mm;
      result.new_seconds        = ss;
      result.mode               = alarm_set_mode_in;
      result.time_frozen        = freeze_flag_in;
      result.clear_fine_timer   = clr_fine;
      result.clear_buzzer_ticks = clr_buzz;
      result.buzzer_action      = action;
      result.restart_startup    = restart;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         minute_hold_count_ff <= 8'd0;
         hour_hold_count_ff   <= 8'd0;
         long_hold_count_ff   <= 8'd0;
         alarm_set_mode_ff    <= 1'b0;
         freeze_flag_ff       <= 1'b0;
         alarm_hours_ff       <= 5'd0;
         alarm_minutes_ff     <= 6'd0;
         hour_matched_ff      <= 1'b0;
         minute_matched_ff    <= 1'b0;
         ring_seconds_ff      <= 14'd0;
      end else if (fire) begin
         minute_hold_count_ff <= minute_hold_count_in;
         hour_hold_count_ff   <= hour_hold_count_in;
         long_hold_count_ff   <= long_hold_count_in;
         alarm_set_mode_ff    <= alarm_set_mode_in;
         freeze_flag_ff       <= freeze_flag_in;
         alarm_hours_ff       <= alarm_hours_in;
         alarm_minutes_ff     <= alarm_minutes_in;
         hour_matched_ff      <= hour_matched_in;
         minute_matched_ff    <= minute_matched_in;
         ring_seconds_ff      <= ring_seconds_in;
      end
   end

endmodule

/* sv/alarm_clock_button_controller.sv */
// An accepted item is loaded into the input register, then moved into the result
// register, where it is offered, once that register is free or draining.
// Throughput: one item per cycle while the result sink keeps up; the controller
// state updates in a single pass as an item moves from the input register
// into the result register. Reset: synchronous, active high; clears the
// controller state and both valid flags and loads the registers with their default values.
module alarm_clock_button_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] minutes_button, [1] hours_button, [2] set_time_button,
   // [3] set_alarm_button, [8:4] clock_hours, [14:9] clock_minutes,
   // [20:15] clock_seconds, [36:21] startup_ticks, [52:37] buzzer_ticks
   input  logic [acbc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [0] opcode
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [4:0] new_hours, [10:5] new_minutes, [16:11] new_seconds, [17] mode,
   // [18] time_frozen, [19] clear_fine_timer, [20] clear_buzzer_ticks,
   // [22:21] buzzer_action, [23] restart_startup
   output logic [acbc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [acbc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [acbc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [acbc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   acbc_pkg::cfg_type      cfg;
   acbc_pkg::req_item_type in_ff, in_in;
   logic                   in_valid_ff, in_valid_in;
   acbc_pkg::rsp_item_type out_ff, core_result;
   logic                   out_valid_ff, out_valid_in;
   logic                   s1_fire;
   logic                   req_fire;
   logic                   frozen_prev_ff, frozen_prev_in;

   acbc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // advance the held item whenever the result register is free or draining
   assign s1_fire    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | s1_fire;
   assign req_fire   = req_tvalid & req_tready;

   always_comb begin
      in_in.opcode           = acbc_pkg::op_type'(req_tuser);
      in_in.minutes_button   = req_tdata[0];
      in_in.hours_button     = req_tdata[1];
      in_in.set_time_button  = req_tdata[2];
      in_in.set_alarm_button = req_tdata[3];
      in_in.clock_hours      = req_tdata[8:4];
      in_in.clock_minutes    = req_tdata[14:9];
      in_in.clock_seconds    = req_tdata[20:15];
      in_in.startup_ticks    = req_tdata[36:21];
      in_in.buzzer_ticks     = req_tdata[52:37];
   end

   assign in_valid_in  = req_fire | (in_valid_ff & ~s1_fire);
   assign out_valid_in = s1_fire | (out_valid_ff & ~rsp_tready);

   acbc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_fire),
      .item   (in_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= in_in;
      end
      if (s1_fire) begin
         out_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.restart_startup, out_ff.buzzer_action,
                        out_ff.clear_buzzer_ticks, out_ff.clear_fine_timer,
                        out_ff.time_frozen, out_ff.mode, out_ff.new_seconds,
                        out_ff.new_minutes, out_ff.new_hours};

   assign frozen_prev_in = s1_fire ? core_result.time_frozen : frozen_prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frozen_prev_ff <= 1'b0;
      end else begin
         frozen_prev_ff <= frozen_prev_in;
      end
   end

   a_fire_fills_output: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> out_valid_ff)
      else $error("item left the input register but no result was loaded");

   a_poll_no_buzzer: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.clear_fine_timer) |->
      (out_ff.buzzer_action == acbc_pkg::BUZZ_KEEP && !out_ff.restart_startup &&
       !out_ff.clear_buzzer_ticks))
      else $error("poll result carries buzzer control");

   a_restart_disables: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.restart_startup) |->
      (out_ff.buzzer_action == acbc_pkg::BUZZ_OFF))
      else $error("alarm reset without buzzer disable");

   a_frozen_on_entry: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !frozen_prev_ff && core_result.time_frozen) |->
      (core_result.new_hours == 5'd0 && core_result.new_minutes == 6'd0 &&
       core_result.new_seconds == 6'd0))
      else $error("freeze entered without zeroing the time");

endmodule

/* sim/alarm_clock_button_controller_tb.sv */
`timescale 1ns / 100ps

module alarm_clock_button_controller_tb;

   localparam logic [3:0] BTN_NONE      = 4'b0000;
   localparam logic [3:0] BTN_MIN       = 4'b0001;
   localparam logic [3:0] BTN_HOUR      = 4'b0010;
   localparam logic [3:0] BTN_SET_TIME  = 4'b0100;
   localparam logic [3:0] BTN_SET_ALARM = 4'b1000;
   localparam int NUM_PHASES = 8;

   typedef struct {
      bit                     is_cfg;
      logic [2:0]             reg_idx;
      logic [7:0]             reg_val;
      acbc_pkg::req_item_type it;
      bit                     typed;
      acbc_pkg::rsp_item_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [acbc_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [acbc_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [acbc_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [acbc_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [acbc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // controller model state
   acbc_pkg::cfg_type cfg_q;
   logic [7:0] min_hold, hour_hold, long_hold;
   logic       alarm_mode_q, frozen_q, hour_hit, minute_hit;
   logic [4:0] alm_hours;
   logic [5:0] alm_minutes;
   logic [13:0] ring_secs;

   acbc_pkg::rsp_item_type want_q[$];
   plan_row_type           plan_q[$];
   acbc_pkg::rsp_item_type seen_rsp, want_rsp;

   int n_errors, n_items, n_polls, n_ticks, n_results, n_reg_writes;
   int n_freezes, n_mode_entries, n_buzz_on, n_alarm_resets;
   int stall_left, sink_roll;
   bit sink_eager, source_eager, choke_req, choke_done;

   alarm_clock_button_controller i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   initial begin
      #(10_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   task report_mismatch(input string msg);
      if (n_errors < 40) $display("ERROR: %s", msg);
      n_errors++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                   n_results, name, got, want));
   endtask

   function automatic bit hold_done(inout logic [7:0] cnt, input logic [7:0] limit);
      cnt = cnt + 8'd1;
      if (cnt >= limit) begin
         cnt = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [5:0] step_wrapped(input logic [5:0] v, input logic [5:0] mask,
                                               input logic [5:0] limit);
      logic [5:0] n;
      n = (v + 6'd1) & mask;
      return (n >= limit) ? 6'd0 : n;
   endfunction

   function automatic acbc_pkg::rsp_item_type predict_response(
      input acbc_pkg::req_item_type it);
      acbc_pkg::rsp_item_type r;
      logic [5:0]   hh, mm, ss;
      logic [31:0]  lockout;
      r = '0;
      r.buzzer_action = acbc_pkg::BUZZ_KEEP;
      hh = {1'b0, it.clock_hours};
      mm = it.clock_minutes;
      ss = it.clock_seconds;
      if (it.opcode == acbc_pkg::OP_POLL) begin
         if (it.minutes_button && !alarm_mode_q) begin
            if (hold_done(min_hold, cfg_q.step_debounce_polls))
               mm = step_wrapped(mm, 6'h3F, acbc_pkg::MINUTES_WRAP);
         end
         if (it.hours_button && !alarm_mode_q) begin
            if (hold_done(hour_hold, cfg_q.step_debounce_polls))
               hh = step_wrapped(hh, 6'h1F, {1'b0, acbc_pkg::HOURS_WRAP});
         end
         // set-time and set-alarm share one hold counter
         if (it.set_time_button) begin
            long_hold = long_hold + 8'd1;
            if (long_hold >= cfg_q.set_time_hold_polls && !frozen_q) begin
               frozen_q = 1'b1;
               hh = '0;
               mm = '0;
               ss = '0;
               long_hold = '0;
               n_freezes++;
            end
            if (long_hold >= cfg_q.set_time_hold_polls && frozen_q) begin
               frozen_q = 1'b0;
               r.clear_fine_timer = 1'b1;
               ss = acbc_pkg::RELEASE_SECOND;
               long_hold = '0;
            end
         end
         if (it.set_alarm_button) begin
            long_hold = long_hold + 8'd1;
            if (long_hold >= cfg_q.set_alarm_hold_polls && !alarm_mode_q) begin
               alarm_mode_q = 1'b1;
               long_hold = '0;
               n_mode_entries++;
            end
            if (long_hold >= cfg_q.set_alarm_hold_polls && alarm_mode_q) begin
               alarm_mode_q = 1'b0;
               r.clear_fine_timer = 1'b1;
               long_hold = '0;
            end
         end
         if (it.minutes_button && alarm_mode_q) begin
            if (hold_done(min_hold, cfg_q.step_debounce_polls))
               alm_minutes = step_wrapped(alm_minutes, 6'h3F, acbc_pkg::MINUTES_WRAP);
         end
         if (it.hours_button && alarm_mode_q) begin
            if (hold_done(hour_hold, cfg_q.step_debounce_polls))
               alm_hours = 5'(step_wrapped({1'b0, alm_hours}, 6'h1F,
                                           {1'b0, acbc_pkg::HOURS_WRAP}));
         end
      end else begin
         lockout = 32'(cfg_q.ticks_per_second) * 32'd60;
         if (32'(it.startup_ticks) >= lockout && !alarm_mode_q) begin
            if (hh[4:0] == alm_hours) hour_hit = 1'b1;
            if (mm == alm_minutes) minute_hit = 1'b1;
            if (hour_hit && minute_hit) begin
               if (it.buzzer_ticks >= 16'(cfg_q.buzzer_on_ticks))
                  r.buzzer_action = acbc_pkg::BUZZ_OFF;
               if (it.buzzer_ticks >= 16'(cfg_q.ticks_per_second)) begin
                  r.clear_buzzer_ticks = 1'b1;
                  r.buzzer_action = acbc_pkg::BUZZ_ON;
                  ring_secs = ring_secs + 14'd1;
               end
            end
            // the alarm-reset disable wins over any enable in this tick
            if (32'(ring_secs) >= 32'(cfg_q.alarm_duration_minutes) * 32'd60) begin
               r.buzzer_action = acbc_pkg::BUZZ_OFF;
               hour_hit = 1'b0;
               minute_hit = 1'b0;
               ring_secs = '0;
               r.restart_startup = 1'b1;
            end
         end
      end
      r.new_hours = hh[4:0];
      r.new_minutes = mm;
      r.new_seconds = ss;
      r.mode = alarm_mode_q;
      r.time_frozen = frozen_q;
      return r;
   endfunction

   function automatic acbc_pkg::req_item_type mk_req(input acbc_pkg::op_type op,
                                                     input logic [3:0] buttons,
                                                     input int hh, input int mm,
                                                     input int ss, input int startup,
                                                     input int bticks);
      acbc_pkg::req_item_type it;
      it.opcode = op;
      it.minutes_button = buttons[0];
      it.hours_button = buttons[1];
      it.set_time_button = buttons[2];
      it.set_alarm_button = buttons[3];
      it.clock_hours = 5'(hh);
      it.clock_minutes = 6'(mm);
      it.clock_seconds = 6'(ss);
      it.startup_ticks = 16'(startup);
      it.buzzer_ticks = 16'(bticks);
      return it;
   endfunction

   function automatic acbc_pkg::rsp_item_type mk_rsp(input int hh, input int mm,
                                                     input int ss, input bit mode,
                                                     input bit frozen, input bit clr_fine,
                                                     input bit clr_buzz,
                                                     input acbc_pkg::buzz_type act,
                                                     input bit restart);
      acbc_pkg::rsp_item_type r;
      r.new_hours = 5'(hh);
      r.new_minutes = 6'(mm);
      r.new_seconds = 6'(ss);
      r.mode = mode;
      r.time_frozen = frozen;
      r.clear_fine_timer = clr_fine;
      r.clear_buzzer_ticks = clr_buzz;
      r.buzzer_action = act;
      r.restart_startup = restart;
      return r;
   endfunction

   function automatic plan_row_type row_item(input acbc_pkg::req_item_type it,
                                             input bit typed,
                                             input acbc_pkg::rsp_item_type want);
      plan_row_type row;
      row = '{is_cfg: 1'b0, reg_idx: '0, reg_val: '0, it: it, typed: typed, want: want};
      return row;
   endfunction

   function automatic plan_row_type row_cfg(input logic [2:0] idx, input logic [7:0] val);
      plan_row_type row;
      row = '{is_cfg: 1'b1, reg_idx: idx, reg_val: val, it: '0, typed: 1'b0, want: '0};
      return row;
   endfunction

   function automatic int rand_hours();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
   endfunction

   function automatic int rand_minutes();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
   endfunction

   function automatic int pick_gap();
      int r;
      if (source_eager) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(input acbc_pkg::req_item_type it, input bit typed,
                            input acbc_pkg::rsp_item_type want);
      int gap;
      acbc_pkg::rsp_item_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.opcode;
      req_tdata <= {3'b0, it.buzzer_ticks, it.startup_ticks, it.clock_seconds,
                    it.clock_minutes, it.clock_hours, it.set_alarm_button,
                    it.set_time_button, it.hours_button, it.minutes_button};
      do @(posedge clock); while (!req_tready);
      predicted = predict_response(it);
      want_q.push_back(typed ? want : predicted);
      n_items++;
      if (it.opcode == acbc_pkg::OP_POLL) n_polls++;
      else n_ticks++;
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [7:0] val);
      req_tvalid <= 1'b0;
      while (want_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= 32'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         acbc_pkg::REG_TICKS_PER_SECOND:       cfg_q.ticks_per_second = val;
         acbc_pkg::REG_ALARM_DURATION_MINUTES: cfg_q.alarm_duration_minutes = val;
         acbc_pkg::REG_STEP_DEBOUNCE_POLLS:    cfg_q.step_debounce_polls = val;
         acbc_pkg::REG_SET_TIME_HOLD_POLLS:    cfg_q.set_time_hold_polls = val;
         acbc_pkg::REG_SET_ALARM_HOLD_POLLS:   cfg_q.set_alarm_hold_polls = val;
         acbc_pkg::REG_BUZZER_ON_TICKS:        cfg_q.buzzer_on_ticks = val;
         default: ;
      endcase
      n_reg_writes++;
   endtask

   task automatic write_all(input acbc_pkg::cfg_type c);
      write_register(acbc_pkg::REG_TICKS_PER_SECOND, c.ticks_per_second);
      write_register(acbc_pkg::REG_ALARM_DURATION_MINUTES, c.alarm_duration_minutes);
      write_register(acbc_pkg::REG_STEP_DEBOUNCE_POLLS, c.step_debounce_polls);
      write_register(acbc_pkg::REG_SET_TIME_HOLD_POLLS, c.set_time_hold_polls);
      write_register(acbc_pkg::REG_SET_ALARM_HOLD_POLLS, c.set_alarm_hold_polls);
      write_register(acbc_pkg::REG_BUZZER_ON_TICKS, c.buzzer_on_ticks);
   endtask

   // Mostly button hold runs and alarm tick runs aimed at the alarm time, some noise.
   task automatic run_phase(input int quota);
      int sent_here, scen, len, k, span, lock, startup, bticks, hh, mm;
      logic [3:0] mask;
      sent_here = 0;
      span = cfg_q.step_debounce_polls;
      if (cfg_q.set_time_hold_polls > span) span = cfg_q.set_time_hold_polls;
      if (cfg_q.set_alarm_hold_polls > span) span = cfg_q.set_alarm_hold_polls;
      span = 2 * span + 2;
      if (span > 64) span = 64;
      while (sent_here < quota) begin
         scen = $urandom_range(0, 99);
         if (scen < 40) begin
            case ($urandom_range(0, 3))
               0: mask = BTN_MIN << $urandom_range(0, 3);
               1: mask = 4'($urandom_range(1, 15));
               2: mask = BTN_SET_TIME;
               default: mask = BTN_SET_ALARM | 4'($urandom_range(0, 3));
            endcase
            len = $urandom_range(1, span);
            for (k = 0; k < len; k++)
               send_item(mk_req(acbc_pkg::OP_POLL, mask, rand_hours(), rand_minutes(),
                                rand_minutes(), $urandom_range(0, 65535),
                                $urandom_range(0, 65535)),
                         1'b0, '0);
            sent_here += len;
         end else if (scen < 85) begin
            len = $urandom_range(1, 24);
            lock = int'(cfg_q.ticks_per_second) * 60;
            for (k = 0; k < len; k++) begin
               startup = ($urandom_range(0, 3) != 0) ? $urandom_range(lock, 65535)
                                                     : $urandom_range(0, 65535);
               hh = ($urandom_range(0, 9) < 6) ? int'(alm_hours) : rand_hours();
               mm = ($urandom_range(0, 9) < 6) ? int'(alm_minutes) : rand_minutes();
               case ($urandom_range(0, 4))
                  0: bticks = $urandom_range(0, 16);
                  1: bticks = int'(cfg_q.ticks_per_second) + $urandom_range(0, 2);
                  2: bticks = int'(cfg_q.buzzer_on_ticks);
                  3: bticks = $urandom_range(0, 300);
                  default: bticks = $urandom_range(0, 65535);
               endcase
               send_item(mk_req(acbc_pkg::OP_TICK, BTN_NONE, hh, mm, rand_minutes(),
                                startup, bticks),
                         1'b0, '0);
            end
            sent_here += len;
         end else begin
            send_item(mk_req(acbc_pkg::op_type'($urandom_range(0, 1)),
                             4'($urandom_range(0, 15)),
                             $urandom_range(0, 31), $urandom_range(0, 63),
                             $urandom_range(0, 63), $urandom_range(0, 65535),
                             $urandom_range(0, 65535)),
                      1'b0, '0);
            sent_here++;
         end
      end
   endtask

   // result sink: random back-pressure, one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (choke_req && !choke_done) begin
         rsp_tready <= 1'b0;
         stall_left <= 400;
         choke_done <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (sink_eager) begin
         rsp_tready <= 1'b1;
      end else begin
         sink_roll = $urandom_range(0, 99);
         if (sink_roll < 65) begin
            rsp_tready <= 1'b1;
         end else if (sink_roll < 95) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp.new_hours = rsp_tdata[4:0];
         seen_rsp.new_minutes = rsp_tdata[10:5];
         seen_rsp.new_seconds = rsp_tdata[16:11];
         seen_rsp.mode = rsp_tdata[17];
         seen_rsp.time_frozen = rsp_tdata[18];
         seen_rsp.clear_fine_timer = rsp_tdata[19];
         seen_rsp.clear_buzzer_ticks = rsp_tdata[20];
         seen_rsp.buzzer_action = acbc_pkg::buzz_type'(rsp_tdata[22:21]);
         seen_rsp.restart_startup = rsp_tdata[23];
         if (want_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", n_results));
         end else begin
            want_rsp = want_q.pop_front();
            check_field("new_hours", 8'(seen_rsp.new_hours), 8'(want_rsp.new_hours));
            check_field("new_minutes", 8'(seen_rsp.new_minutes), 8'(want_rsp.new_minutes));
            check_field("new_seconds", 8'(seen_rsp.new_seconds), 8'(want_rsp.new_seconds));
            check_field("mode", 8'(seen_rsp.mode), 8'(want_rsp.mode));
            check_field("time_frozen", 8'(seen_rsp.time_frozen), 8'(want_rsp.time_frozen));
            check_field("clear_fine_timer", 8'(seen_rsp.clear_fine_timer),
                        8'(want_rsp.clear_fine_timer));
            check_field("clear_buzzer_ticks", 8'(seen_rsp.clear_buzzer_ticks),
                        8'(want_rsp.clear_buzzer_ticks));
            check_field("buzzer_action", 8'(seen_rsp.buzzer_action),
                        8'(want_rsp.buzzer_action));
            check_field("restart_startup", 8'(seen_rsp.restart_startup),
                        8'(want_rsp.restart_startup));
         end
         if (seen_rsp.buzzer_action == acbc_pkg::BUZZ_ON) n_buzz_on++;
         if (seen_rsp.restart_startup) n_alarm_resets++;
         n_results++;
      end
   end

   initial begin
      acbc_pkg::cfg_type pc;
      int phase, quota, drain;
      cfg_q = '{acbc_pkg::RST_TICKS_PER_SECOND, acbc_pkg::RST_ALARM_DURATION_MINUTES,
                acbc_pkg::RST_STEP_DEBOUNCE_POLLS, acbc_pkg::RST_SET_TIME_HOLD_POLLS,
                acbc_pkg::RST_SET_ALARM_HOLD_POLLS, acbc_pkg::RST_BUZZER_ON_TICKS};
      {min_hold, hour_hold, long_hold} = '0;
      {alarm_mode_q, frozen_q, hour_hit, minute_hit} = '0;
      alm_hours = '0;
      alm_minutes = '0;
      ring_secs = '0;

      // defaults after reset: pass-through, wrap of stepped time, alarm at 00:00
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_POLL, BTN_NONE, 23, 59, 59, 0, 0), 1'b1,
                                mk_rsp(23, 59, 59, 0, 0, 0, 0, acbc_pkg::BUZZ_KEEP, 0)));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_POLL, BTN_NONE, 31, 63, 63, 65535,
                                       65535), 1'b1,
                                mk_rsp(31, 63, 63, 0, 0, 0, 0, acbc_pkg::BUZZ_KEEP, 0)));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_TICK, BTN_NONE, 5, 6, 7, 0, 65535), 1'b1,
                                mk_rsp(5, 6, 7, 0, 0, 0, 0, acbc_pkg::BUZZ_KEEP, 0)));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_POLL, BTN_MIN, 12, 59, 1, 0, 0),
                                1'b0, '0));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_POLL, BTN_MIN, 12, 59, 1, 0, 0),
                                1'b0, '0));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_POLL, BTN_MIN | BTN_HOUR, 31, 63, 2,
                                       0, 0), 1'b0, '0));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_POLL, BTN_MIN | BTN_HOUR, 31, 63, 2,
                                       0, 0), 1'b0, '0));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_TICK, BTN_NONE, 0, 0, 17, 65535, 65535),
                                1'b1,
                                mk_rsp(0, 0, 17, 0, 0, 0, 1, acbc_pkg::BUZZ_ON, 0)));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_TICK, BTN_NONE, 0, 0, 18, 480, 4),
                                1'b0, '0));
      // short holds so that freeze, release and the mode switch show up quickly
      plan_q.push_back(row_cfg(acbc_pkg::REG_TICKS_PER_SECOND, 8'd1));
      plan_q.push_back(row_cfg(acbc_pkg::REG_ALARM_DURATION_MINUTES, 8'd0));
      plan_q.push_back(row_cfg(acbc_pkg::REG_STEP_DEBOUNCE_POLLS, 8'd1));
      plan_q.push_back(row_cfg(acbc_pkg::REG_SET_TIME_HOLD_POLLS, 8'd2));
      plan_q.push_back(row_cfg(acbc_pkg::REG_SET_ALARM_HOLD_POLLS, 8'd3));
      plan_q.push_back(row_cfg(acbc_pkg::REG_BUZZER_ON_TICKS, 8'd0));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_TICK, BTN_NONE, 0, 0, 0, 60, 0),
                                1'b0, '0));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_POLL, BTN_SET_TIME, 12, 34, 56, 0, 0),
                                1'b0, '0));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_POLL, BTN_SET_TIME, 12, 34, 56, 0, 0),
                                1'b0, '0));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_POLL, BTN_SET_TIME, 0, 0, 9, 0, 0),
                                1'b0, '0));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_POLL, BTN_SET_TIME, 0, 0, 9, 0, 0),
                                1'b0, '0));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_POLL,
                                       BTN_SET_TIME | BTN_SET_ALARM | BTN_MIN,
                                       1, 2, 3, 0, 0), 1'b0, '0));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_POLL, BTN_SET_ALARM | BTN_MIN,
                                       1, 2, 3, 0, 0), 1'b0, '0));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_POLL, BTN_HOUR, 1, 2, 3, 0, 0),
                                1'b0, '0));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_TICK, BTN_NONE, 1, 1, 3, 65535, 65535),
                                1'b0, '0));
      plan_q.push_back(row_cfg(acbc_pkg::REG_SET_TIME_HOLD_POLLS, 8'd0));
      plan_q.push_back(row_item(mk_req(acbc_pkg::OP_POLL, BTN_SET_TIME, 7, 8, 9, 0, 0),
                                1'b0, '0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_q[i]) begin
         if (plan_q[i].is_cfg) write_register(plan_q[i].reg_idx, plan_q[i].reg_val);
         else send_item(plan_q[i].it, plan_q[i].typed, plan_q[i].want);
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: pc = '{8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd0};
            1: pc = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
            2: pc = '{acbc_pkg::RST_TICKS_PER_SECOND, acbc_pkg::RST_ALARM_DURATION_MINUTES,
                      acbc_pkg::RST_STEP_DEBOUNCE_POLLS, acbc_pkg::RST_SET_TIME_HOLD_POLLS,
                      acbc_pkg::RST_SET_ALARM_HOLD_POLLS, acbc_pkg::RST_BUZZER_ON_TICKS};
            4: pc = '0;
            default: pc = '{8'($urandom_range(1, 4)), 8'($urandom_range(1, 2)),
                            8'($urandom_range(1, 4)), 8'($urandom_range(2, 12)),
                            8'($urandom_range(2, 12)), 8'($urandom_range(0, 4))};
         endcase
         quota = (phase == 1 || phase == 4) ? 150 : (phase == 0 || phase == 2) ? 230 :
                 (phase == 3) ? 250 : 280;
         write_all(pc);
         // pressure phase: sender never idles while the sink holds off
         source_eager <= (phase == 3) || ($urandom_range(0, 3) == 0);
         sink_eager <= (phase != 3) && ($urandom_range(0, 3) == 0);
         if (phase == 3) choke_req <= 1'b1;
         run_phase(quota);
      end

      req_tvalid <= 1'b0;
      for (drain = 0; drain < 10000 && want_q.size() != 0; drain++) @(posedge clock);
      if (want_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", want_q.size()));
      repeat (8) @(posedge clock);

      $display("Covered %0d items (%0d polls, %0d alarm ticks), %0d register writes,",
               n_items, n_polls, n_ticks, n_reg_writes);
      $display("%0d freezes, %0d alarm-set entries, %0d buzzer enables, %0d alarm resets",
               n_freezes, n_mode_entries, n_buzz_on, n_alarm_resets);
      if (n_errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
sv/acbc_pkg.sv
sv/acbc_csr.sv
sv/acbc_core.sv
sv/alarm_clock_button_controller.sv
sim/alarm_clock_button_controller_tb.sv
